[src/ptd_pkg.sv]
// shared constants and codes for the periodic task dispatcher
`timescale 1ns / 1ps

package ptd_pkg;

    localparam int KIND_W      = 3;
    localparam int FIELD_W     = 8;
    localparam int STATUS_W    = 2;
    localparam int TASK_SLOT_W = 6;
    localparam int WORD_W      = 2 * FIELD_W;

    localparam logic [KIND_W-1:0] KIND_TICK    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_CREATE  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DELETE  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_SUSPEND = 3'd3;
    localparam logic [KIND_W-1:0] KIND_RESUME  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BUSY  = 2'd2;

    // one slot entry: reload period in the upper byte, countdown in the lower
    typedef struct packed {
        logic [FIELD_W-1:0] period;
        logic [FIELD_W-1:0] count;
    } t_slot_word;

endpackage

[src/ptd_slot_ram.sv]
// slot table memory: one write port, one registered read port
`timescale 1ns / 1ps

module ptd_slot_ram #(
    parameter int DEPTH = 8,
    parameter int AW    = 3
) (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [AW-1:0]              i_wr_addr,
    input  ptd_pkg::t_slot_word        i_wr_data,
    input  logic                       i_rd_en,
    input  logic [AW-1:0]              i_rd_addr,
    output ptd_pkg::t_slot_word        o_rd_data
);

    ptd_pkg::t_slot_word r_mem [DEPTH];
    ptd_pkg::t_slot_word r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[src/periodic_task_dispatcher_core.sv]
// top level of the periodic task dispatcher: command decode and tick walker
`timescale 1ns / 1ps

// A create, delete, suspend or resume request is taken when start is high and
// busy is low and answers with one result on the following cycle, so such
// requests can be issued back to back. A tick request walks the slot table in
// memory one slot a cycle, from slot 0 upward, doing a read, update and write
// back per slot, with busy high until its last result appears. Each result is
// valid for the single cycle in which o_valid is high and cannot be stalled; a
// tick gives one result per firing slot in ascending order, or one result with
// o_fired low, and o_last marks the final result of every request. No clearing
// pass is needed after reset.
module periodic_task_dispatcher_core #(
    parameter int TASK_SLOTS = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [ptd_pkg::KIND_W-1:0]         i_kind,
    input  logic [ptd_pkg::FIELD_W-1:0]        i_slot,
    input  logic [ptd_pkg::FIELD_W-1:0]        i_period,
    input  logic [ptd_pkg::FIELD_W-1:0]        i_first_delay,
    output logic                               o_valid,
    output logic [ptd_pkg::STATUS_W-1:0]       o_status,
    output logic                               o_fired,
    output logic [ptd_pkg::TASK_SLOT_W-1:0]    o_task_slot,
    output logic                               o_last
);

    localparam int IW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(TASK_SLOTS - 1);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_WALK   = 3'b010,
        S_FINISH = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic [TASK_SLOTS-1:0] r_used, n_used;
    logic [TASK_SLOTS-1:0] r_ready, n_ready;
    logic                  r_rd_act, n_rd_act;
    logic [IW-1:0]         r_rd_idx, n_rd_idx;
    logic                  r_chk_v, n_chk_v;
    logic [IW-1:0]         r_chk_idx, n_chk_idx;
    logic                  r_pend, n_pend;
    logic [IW-1:0]         r_pend_idx, n_pend_idx;
    logic                  r_valid, n_valid;
    logic [ptd_pkg::STATUS_W-1:0]    r_status, n_status;
    logic                            r_fired, n_fired;
    logic [ptd_pkg::TASK_SLOT_W-1:0] r_task_slot, n_task_slot;
    logic                            r_last, n_last;

    logic                accept;
    logic                in_range;
    logic [IW-1:0]       cmd_idx;
    logic                wr_en;
    logic [IW-1:0]       wr_addr;
    ptd_pkg::t_slot_word wr_data;
    logic                rd_en;
    logic [IW-1:0]       rd_addr;
    ptd_pkg::t_slot_word rd_data;

    ptd_slot_ram #(
        .DEPTH (TASK_SLOTS),
        .AW    (IW)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign busy     = (r_state != S_IDLE);
    assign accept   = start && !busy;
    assign in_range = ({1'b0, i_slot} < 9'(TASK_SLOTS));
    assign cmd_idx  = i_slot[IW-1:0];

    always_comb begin
        n_state     = r_state;
        n_used      = r_used;
        n_ready     = r_ready;
        n_rd_act    = r_rd_act;
        n_rd_idx    = r_rd_idx;
        n_chk_v     = 1'b0;
        n_chk_idx   = r_chk_idx;
        n_pend      = r_pend;
        n_pend_idx  = r_pend_idx;
        n_valid     = 1'b0;
        n_status    = ptd_pkg::ST_OK;
        n_fired     = 1'b0;
        n_task_slot = '0;
        n_last      = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = cmd_idx;
        wr_data     = '{period: i_period, count: i_first_delay};
        rd_en       = 1'b0;
        rd_addr     = r_rd_idx;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_kind == ptd_pkg::KIND_TICK) begin
                        n_rd_act = 1'b1;
                        n_rd_idx = '0;
                        n_pend   = 1'b0;
                        n_state  = S_WALK;
                    end else begin
                        n_valid = 1'b1;
                        n_last  = 1'b1;
                        case (i_kind)
                            ptd_pkg::KIND_CREATE: begin
                                if (!in_range) begin
                                    n_status = ptd_pkg::ST_RANGE;
                                end else if (r_used[cmd_idx]) begin
                                    n_status = ptd_pkg::ST_BUSY;
                                end else begin
                                    n_used[cmd_idx]  = 1'b1;
                                    n_ready[cmd_idx] = 1'b1;
                                    wr_en            = 1'b1;
                                end
                            end
                            ptd_pkg::KIND_DELETE: begin
                                if (in_range && r_used[cmd_idx]) begin
                                    n_used[cmd_idx]  = 1'b0;
                                    n_ready[cmd_idx] = 1'b0;
                                    wr_en            = 1'b1;
                                    wr_data          = '0;
                                end
                            end
                            ptd_pkg::KIND_SUSPEND: begin
                                if (in_range && r_used[cmd_idx]) begin
                                    n_ready[cmd_idx] = 1'b0;
                                end
                            end
                            ptd_pkg::KIND_RESUME: begin
                                if (in_range && r_used[cmd_idx]) begin
                                    n_ready[cmd_idx] = 1'b1;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end
            S_WALK: begin
                // read stage: one slot address per cycle
                rd_en     = r_rd_act;
                n_chk_v   = r_rd_act;
                n_chk_idx = r_rd_idx;
                if (r_rd_act) begin
                    if (r_rd_idx == LAST_IDX) begin
                        n_rd_act = 1'b0;
                    end else begin
                        n_rd_idx = r_rd_idx + IW'(1);
                    end
                end
                // update stage: writes back the slot read in the previous cycle, if it is used and ready
                if (r_chk_v) begin
                    wr_addr = r_chk_idx;
                    if (r_used[r_chk_idx] && r_ready[r_chk_idx]) begin
                        wr_en = 1'b1;
                        if (rd_data.count == '0) begin
                            wr_data = '{period: rd_data.period, count: rd_data.period};
                            // a fire is held back until the next one shows it was not last
                            if (r_pend) begin
                                n_valid     = 1'b1;
                                n_fired     = 1'b1;
                                n_task_slot = ptd_pkg::TASK_SLOT_W'(r_pend_idx);
                            end
                            n_pend     = 1'b1;
                            n_pend_idx = r_chk_idx;
                        end else begin
                            wr_data = '{period: rd_data.period,
                                        count: rd_data.count - ptd_pkg::FIELD_W'(1)};
                        end
                    end
                    if (r_chk_idx == LAST_IDX) begin
                        n_state = S_FINISH;
                    end
                end
            end
            S_FINISH: begin
                n_valid = 1'b1;
                n_last  = 1'b1;
                n_fired = r_pend;
                if (r_pend) begin
                    n_task_slot = ptd_pkg::TASK_SLOT_W'(r_pend_idx);
                end
                n_pend  = 1'b0;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_used   <= '0;
            r_ready  <= '0;
            r_rd_act <= 1'b0;
            r_chk_v  <= 1'b0;
            r_pend   <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_used   <= n_used;
            r_ready  <= n_ready;
            r_rd_act <= n_rd_act;
            r_chk_v  <= n_chk_v;
            r_pend   <= n_pend;
            r_valid  <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx    <= n_rd_idx;
        r_chk_idx   <= n_chk_idx;
        r_pend_idx  <= n_pend_idx;
        r_status    <= n_status;
        r_fired     <= n_fired;
        r_task_slot <= n_task_slot;
        r_last      <= n_last;
    end

    assign o_valid     = r_valid;
    assign o_status    = r_status;
    assign o_fired     = r_fired;
    assign o_task_slot = r_task_slot;
    assign o_last      = r_last;

endmodule
